FILE: rtl/pcc_pkg.sv
// pcc_pkg: shared types and constants for the psi cycle cutter.
// No dependencies; used by every file in rtl/.
package pcc_pkg;

   localparam int DATA_W        = 10;
   localparam int DEPTH_DEFAULT = 1024;

   // request action codes
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_FETCH = 1'b1;

   typedef struct packed {
      logic              action;
      logic [DATA_W-1:0] entry_value;
      logic              final_entry;
   } req_word_type;

   typedef struct packed {
      logic [DATA_W-1:0] adjusted_value;
      logic              final_result;
   } rsp_word_type;

endpackage

FILE: rtl/psi_cycle_cutter_unit.sv
// psi_cycle_cutter_unit: loads a psi permutation, cuts it into runs, drains it.
// Depends on pcc_pkg and pcc_store. A non-final load leaves the unit idle. A fetch
// result passes the store read register and the output register; the next word
// waits until the result enters the output register. A final load adds a walk
// (start step, k successor steps, k <= n) on the single read port of pcc_store.
// Reset (synchronous): phase loading, count 0, drain index 1; store not cleared.
module psi_cycle_cutter_unit #(
   parameter int DEPTH = pcc_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pcc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pcc_pkg::rsp_word_type rsp_word
);

   localparam int DW   = pcc_pkg::DATA_W;
   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);     // holds 0..DEPTH
   localparam int CMPW = (CW > DW) ? CW : DW;    // index vs. DEPTH compare

   // control states
   localparam logic [1:0] ST_IDLE       = 2'd0;
   localparam logic [1:0] ST_WALK_START = 2'd1;
   localparam logic [1:0] ST_WALK       = 2'd2;
   localparam logic [1:0] ST_FETCH_WAIT = 2'd3;

   // array phases
   localparam logic [1:0] PH_LOADING  = 2'd0;
   localparam logic [1:0] PH_DRAINING = 2'd1;
   localparam logic [1:0] PH_DONE     = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [1:0]    phase_ff, phase_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] drain_ff, drain_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic [DW-1:0] pos_ff, pos_in;
   logic [DW-1:0] run_ff, run_in;
   logic          oob_ff, oob_in;      // pending read was beyond the store
   logic          last_ff, last_in;    // pending fetch is the last entry
   logic          rsp_valid_ff, rsp_valid_in;
   pcc_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // store port
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [DW-1:0] wr_data, rd_data;

   // handshake
   logic          req_fire;
   logic          rsp_free;

   // walk and drain helpers
   logic [DW-1:0] next_val;
   logic [CW-1:0] base_count;
   logic [CW-1:0] steps_inc;
   logic [CW:0]   drain_plus2;
   logic          walk_back;
   logic          walk_go_on;

   pcc_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // a walk index beyond the store reads as zero
   assign next_val    = oob_ff ? '0 : rd_data;
   assign walk_back   = (pos_ff > next_val);
   assign steps_inc   = steps_ff + CW'(1);
   assign walk_go_on  = (next_val != '0) && (steps_inc < count_ff);
   assign base_count  = (phase_ff != PH_LOADING) ? '0 : count_ff;
   assign drain_plus2 = {1'b0, drain_ff} + (CW+1)'(2);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      drain_in     = drain_ff;
      steps_in     = steps_ff;
      pos_in       = pos_ff;
      run_in       = run_ff;
      oob_in       = oob_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_word.action == pcc_pkg::ACT_LOAD) begin
                  // a load after the cut opens a new array
                  phase_in = PH_LOADING;
                  count_in = base_count;
                  if (base_count < CW'(DEPTH)) begin
                     wr_en    = 1'b1;
                     wr_addr  = AW'(base_count);
                     wr_data  = req_word.entry_value;
                     count_in = base_count + CW'(1);
                  end
                  if (req_word.final_entry) begin
                     state_in = ST_WALK_START;
                  end
               end else if (phase_ff == PH_DRAINING) begin
                  if ((drain_plus2 > {1'b0, count_ff}) || (drain_ff >= CW'(DEPTH))) begin
                     phase_in = PH_DONE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = AW'(drain_ff);
                     oob_in   = 1'b0;
                     last_in  = (drain_plus2 == {1'b0, count_ff});
                     drain_in = drain_ff + CW'(1);
                     if (drain_plus2 == {1'b0, count_ff}) begin
                        phase_in = PH_DONE;
                     end
                     state_in = ST_FETCH_WAIT;
                  end
               end
            end
         end

         ST_WALK_START: begin
            // store write of the final load has landed; read entry 0
            pos_in   = '0;
            run_in   = '0;
            steps_in = '0;
            rd_en    = 1'b1;
            rd_addr  = '0;
            oob_in   = 1'b0;
            state_in = ST_WALK;
         end

         ST_WALK: begin
            // one successor step per cycle; the write goes to the old index
            // and the read to the new one, so they never collide
            if (walk_back) begin
               run_in = next_val;
               if (CMPW'(pos_ff) < CMPW'(DEPTH)) begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(pos_ff);
                  wr_data = run_ff;
               end
            end
            pos_in   = next_val;
            steps_in = steps_inc;
            if (walk_go_on) begin
               rd_en   = 1'b1;
               rd_addr = AW'(next_val);
               oob_in  = !(CMPW'(next_val) < CMPW'(DEPTH));
            end else begin
               drain_in = CW'(1);
               phase_in = (count_ff >= CW'(3)) ? PH_DRAINING : PH_DONE;
               state_in = ST_IDLE;
            end
         end

         ST_FETCH_WAIT: begin
            // hold the read word until the output register is free
            if (rsp_free) begin
               rsp_valid_in                = 1'b1;
               rsp_word_in.adjusted_value = rd_data - DW'(1);
               rsp_word_in.final_result   = last_ff;
               state_in                    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_LOADING;
         count_ff     <= '0;
         drain_ff     <= CW'(1);
         steps_ff     <= '0;
         pos_ff       <= '0;
         run_ff       <= '0;
         oob_ff       <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         drain_ff     <= drain_in;
         steps_ff     <= steps_in;
         pos_ff       <= pos_in;
         run_ff       <= run_in;
         oob_ff       <= oob_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

FILE: rtl/pcc_store.sv
// pcc_store: successor store, one write port and one registered read port.
// Depends on pcc_pkg for the entry width.
module pcc_store #(
   parameter int DEPTH = pcc_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [pcc_pkg::DATA_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [pcc_pkg::DATA_W-1:0]  rd_data
);

   logic [pcc_pkg::DATA_W-1:0] mem [DEPTH];
   logic [pcc_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pcc_checker.sv
// pcc_checker: port-level assertions for psi_cycle_cutter_unit, bound below.
// Depends on pcc_pkg for the word types.
module pcc_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input pcc_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input pcc_pkg::rsp_word_type rsp_word
);

   logic req_fire;
   assign req_fire = req_valid && !req_stall;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // a fresh result follows a fetch through the store read register and the output register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_fire, 2) && ($past(req_word.action, 2) == pcc_pkg::ACT_FETCH))
      else $error("result word without a fetch two cycles before");

   // a final load starts the walk, which blocks the request side
   a_walk_blocks: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_word.action == pcc_pkg::ACT_LOAD) && req_word.final_entry
         |=> req_stall)
      else $error("request taken right after a final load");

   // no result after reset until a fetch arrives
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind psi_cycle_cutter_unit pcc_checker u_pcc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

FILE: sim/tb.sv
// tb: self-checking testbench for psi_cycle_cutter_unit (load, cut walk, drain).
// Depends on pcc_pkg and the RTL under rtl/; predicts drained words, bar pinned rows.
// Directed table first, then random arrays under four idle/stall mixes.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = pcc_pkg::DEPTH_DEFAULT;
   localparam int DW          = pcc_pkg::DATA_W;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 160;

   // short names for the action codes, used by the directed table
   localparam logic DO_LOAD  = pcc_pkg::ACT_LOAD;
   localparam logic DO_FETCH = pcc_pkg::ACT_FETCH;

   // one directed row: request word, and optionally a hand-typed outcome
   typedef struct packed {
      logic          act;
      logic [DW-1:0] val;
      logic          fin;
      logic          pinned;   // 1: outcome below is typed in, not predicted
      logic          has;
      logic [DW-1:0] out;
      logic          last;
   } dir_row_type;

   typedef enum logic [1:0] {ST_LOAD, ST_DRAIN, ST_DONE} cut_state_type;
   typedef enum int {SEQ_CYCLE, SEQ_PERM, SEQ_NOISE} seq_kind_type;

   localparam dir_row_type DIR_TAB [22] = '{
      '{DO_FETCH, 10'd0,    1'b0, 1'b1, 1'b0, 10'd0,    1'b0}, // fetch straight after reset
      '{DO_LOAD,  10'd2,    1'b0, 1'b0, 1'b0, 10'd0,    1'b0}, // 4-entry cycle 0-2-1-3
      '{DO_LOAD,  10'd3,    1'b0, 1'b0, 1'b0, 10'd0,    1'b0},
      '{DO_LOAD,  10'd1,    1'b0, 1'b0, 1'b0, 10'd0,    1'b0},
      '{DO_LOAD,  10'd0,    1'b1, 1'b0, 1'b0, 10'd0,    1'b0}, // cut starts here
      '{DO_FETCH, 10'd0,    1'b0, 1'b0, 1'b0, 10'd0,    1'b0},
      '{DO_FETCH, 10'd0,    1'b1, 1'b1, 1'b1, 10'd1023, 1'b1}, // cut entry 0 wraps to all ones
      '{DO_FETCH, 10'd0,    1'b0, 1'b1, 1'b0, 10'd0,    1'b0}, // nothing left
      '{DO_LOAD,  10'd1,    1'b0, 1'b0, 1'b0, 10'd0,    1'b0}, // two-entry array: no drain
      '{DO_LOAD,  10'd0,    1'b1, 1'b0, 1'b0, 10'd0,    1'b0},
      '{DO_FETCH, 10'd0,    1'b0, 1'b1, 1'b0, 10'd0,    1'b0},
      '{DO_LOAD,  10'd0,    1'b0, 1'b0, 1'b0, 10'd0,    1'b0}, // 0 points at itself
      '{DO_LOAD,  10'd1023, 1'b0, 1'b0, 1'b0, 10'd0,    1'b0}, // max value, off the walk
      '{DO_LOAD,  10'd5,    1'b1, 1'b0, 1'b0, 10'd0,    1'b0},
      '{DO_FETCH, 10'd1023, 1'b0, 1'b1, 1'b1, 10'd1022, 1'b1},
      '{DO_LOAD,  10'd1,    1'b0, 1'b0, 1'b0, 10'd0,    1'b0}, // walk never returns to 0
      '{DO_LOAD,  10'd2,    1'b0, 1'b0, 1'b0, 10'd0,    1'b0},
      '{DO_LOAD,  10'd3,    1'b0, 1'b0, 1'b0, 10'd0,    1'b0},
      '{DO_LOAD,  10'd3,    1'b1, 1'b0, 1'b0, 10'd0,    1'b0},
      '{DO_FETCH, 10'd0,    1'b0, 1'b0, 1'b0, 10'd0,    1'b0},
      '{DO_LOAD,  10'd0,    1'b1, 1'b0, 1'b0, 10'd0,    1'b0}, // abandons the drain, n = 1
      '{DO_FETCH, 10'd0,    1'b1, 1'b1, 1'b0, 10'd0,    1'b0}
   };

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   pcc_pkg::req_word_type req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   pcc_pkg::rsp_word_type rsp_word;

   // typed outcome riding along with the word on the request port
   logic                  pin_valid = 1'b0;
   logic                  pin_has   = 1'b0;
   pcc_pkg::rsp_word_type pin_rsp   = '0;

   int send_idle_pct = 0;
   int stall_pct     = 0;

   // predictor state
   logic [DW-1:0]  psi_mem [DEPTH];
   int unsigned    n_loaded  = 0;
   int unsigned    walk_pos  = 0;
   int unsigned    run_head  = 0;
   int unsigned    drain_pos = 1;
   cut_state_type  cut_state = ST_LOAD;

   pcc_pkg::rsp_word_type drained_q [$];

   // stimulus-side view of the store: which positions hold a written entry
   int gen_pos   = 0;
   bit gen_fresh = 1'b1;
   int gen_hw    = 0;

   int cycle_count     = 0;
   int items_sent      = 0;
   int loads_taken     = 0;
   int results_checked = 0;
   int walks_done      = 0;
   int fail_count      = 0;

   psi_cycle_cutter_unit #(.DEPTH(DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Walk from 0 along successors; on each backward jump the current entry
   // takes the previous run start and the run start moves to the target.
   function automatic void cut_runs();
      int unsigned nxt;
      int unsigned steps;
      walk_pos = 0;
      run_head = 0;
      steps    = 0;
      nxt      = psi_mem[0];
      do begin
         if (walk_pos > nxt) begin
            if (walk_pos < DEPTH) psi_mem[walk_pos] = run_head[DW-1:0];
            run_head = nxt;
         end
         walk_pos = nxt;
         nxt      = (nxt < DEPTH) ? psi_mem[nxt] : 0;
         steps++;
      end while (walk_pos != 0 && steps < n_loaded);
      drain_pos = 1;
      cut_state = (n_loaded >= 3) ? ST_DRAIN : ST_DONE;
   endfunction

   // Returns 1 when the word yields a drained word, which goes to r.
   function automatic bit cutter_predict(input pcc_pkg::req_word_type w,
                                         output pcc_pkg::rsp_word_type r);
      r = '0;
      if (w.action == pcc_pkg::ACT_LOAD) begin
         if (cut_state != ST_LOAD) begin
            n_loaded  = 0;
            cut_state = ST_LOAD;
         end
         if (n_loaded < DEPTH) begin
            psi_mem[n_loaded] = w.entry_value;
            n_loaded++;
         end
         if (w.final_entry) begin
            cut_runs();
            walks_done++;
         end
         return 1'b0;
      end
      if (cut_state != ST_DRAIN) return 1'b0;
      if (drain_pos + 2 > n_loaded || drain_pos >= DEPTH) begin
         cut_state = ST_DONE;
         return 1'b0;
      end
      r.adjusted_value = psi_mem[drain_pos] - 1'b1;
      r.final_result   = (drain_pos + 2 == n_loaded);
      drain_pos++;
      if (r.final_result) cut_state = ST_DONE;
      return 1'b1;
   endfunction

   // Present one word, with random idle cycles ahead of it, and hold it until taken.
   // Valid is only lowered on an idle cycle, so back-to-back words never toggle it.
   task automatic send(input pcc_pkg::req_word_type w, input bit pin, input bit p_has,
                       input pcc_pkg::rsp_word_type p_rsp);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      pin_valid <= pin;
      pin_has   <= p_has;
      pin_rsp   <= p_rsp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (w.action == pcc_pkg::ACT_LOAD) begin
         if (gen_fresh) begin
            gen_pos   = 0;
            gen_fresh = 1'b0;
         end
         if (gen_pos < DEPTH) gen_pos++;
         if (gen_pos > gen_hw) gen_hw = gen_pos;
         if (w.final_entry) gen_fresh = 1'b1;
      end
   endtask

   // One array: n entries (plus spill loads past the store), stray fetches among them, then more fetches.
   // Values only ever point at written positions so the walk reads known data.
   task automatic run_array(input int n, input int spill, input seq_kind_type kind,
                            input bit closes);
      int                    vals [];
      int                    order [];
      int                    base;
      int                    lim;
      int                    j;
      int                    tmp;
      int                    nf;
      pcc_pkg::req_word_type w;
      base = gen_fresh ? 0 : gen_pos;
      lim  = (base + n > gen_hw) ? base + n : gen_hw;
      if (lim > DEPTH) lim = DEPTH;
      vals  = new[n];
      order = new[n];
      foreach (order[i]) order[i] = i;
      for (int i = n - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      case (kind)
         SEQ_CYCLE: foreach (order[i]) vals[order[i]] = order[(i + 1) % n];
         SEQ_PERM:  vals = order;
         default:   foreach (vals[i]) vals[i] = $urandom_range(0, lim - 1);
      endcase
      for (int i = 0; i < n + spill; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            w.action      = pcc_pkg::ACT_FETCH;
            w.entry_value = DW'($urandom_range(0, DEPTH - 1));
            w.final_entry = 1'($urandom_range(0, 1));
            send(w, 1'b0, 1'b0, '0);
         end
         w.action      = pcc_pkg::ACT_LOAD;
         w.entry_value = (i < n) ? DW'(vals[i]) : DW'($urandom_range(0, DEPTH - 1));
         w.final_entry = closes && (i == n + spill - 1);
         send(w, 1'b0, 1'b0, '0);
      end
      if (n + spill > 100) nf = 30;
      else if (!closes || $urandom_range(0, 3) == 0) nf = $urandom_range(0, n);
      else nf = ((n > 2) ? n - 2 : 0) + $urandom_range(0, 2);
      repeat (nf) begin
         w.action      = pcc_pkg::ACT_FETCH;
         w.entry_value = DW'($urandom_range(0, DEPTH - 1));
         w.final_entry = 1'($urandom_range(0, 1));
         send(w, 1'b0, 1'b0, '0);
      end
   endtask

   // receiver: random stall per cycle, never during reset
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Both channels are sampled here at the edge, before any NBA of this step lands.
   always @(posedge clock) begin : monitor
      pcc_pkg::rsp_word_type guess;
      pcc_pkg::rsp_word_type want;
      bit                    has;
      if (!reset && req_valid && !req_stall) begin
         has = cutter_predict(req_word, guess);
         if (pin_valid) begin
            has   = pin_has;
            guess = pin_rsp;
         end
         if (req_word.action == pcc_pkg::ACT_LOAD) loads_taken++;
         if (has) drained_q.push_back(guess);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drained_q.size() == 0) begin
            $display("%0t: drained word expected none actual %h", $time, rsp_word);
            fail_count++;
         end else begin
            want = drained_q.pop_front();
            results_checked++;
            if (rsp_word.adjusted_value !== want.adjusted_value) begin
               $display("%0t: adjusted_value expected %0d actual %0d", $time,
                        want.adjusted_value, rsp_word.adjusted_value);
               fail_count++;
            end
            if (rsp_word.final_result !== want.final_result) begin
               $display("%0t: final_result expected %0d actual %0d", $time,
                        want.final_result, rsp_word.final_result);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d drained words still due", $time, drained_q.size());
         $display("tb failed");
         $finish;
      end
   end

   initial begin : stimulus
      pcc_pkg::req_word_type w;
      pcc_pkg::rsp_word_type pr;
      int                    r;
      int                    n;
      int                    phase_start;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table, light idling on both sides
      send_idle_pct = 13;
      stall_pct     = 13;
      foreach (DIR_TAB[i]) begin
         w.action          = DIR_TAB[i].act;
         w.entry_value     = DIR_TAB[i].val;
         w.final_entry     = DIR_TAB[i].fin;
         pr.adjusted_value = DIR_TAB[i].out;
         pr.final_result   = DIR_TAB[i].last;
         send(w, DIR_TAB[i].pinned, DIR_TAB[i].has, pr);
      end

      // random arrays; idle mix per phase: none, sender, receiver, both
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 85; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 85; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
         endcase
         // one full-size cycle with loads spilling past the store
         if (ph == 0) run_array(DEPTH, 2, SEQ_CYCLE, 1'b1);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 60) : $urandom_range(3, 24);
            if (r < 65)      run_array(n, 0, SEQ_CYCLE, $urandom_range(0, 11) != 0);
            else if (r < 78) run_array(n, 0, SEQ_PERM, $urandom_range(0, 11) != 0);
            else if (r < 92) run_array(n, 0, SEQ_NOISE, $urandom_range(0, 11) != 0);
            else             run_array($urandom_range(1, 2), 0, SEQ_CYCLE, 1'b1);
         end
      end
      req_valid <= 1'b0;

      while (drained_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (drained_q.size() != 0) fail_count++;

      $display("Covered %0d words (%0d loads, %0d cut walks), %0d drained words checked.",
               items_sent, loads_taken, walks_done, results_checked);
      $display("Idle mixes: none, sender 85%%, receiver 85%%, both 13%%; %0d mismatches.",
               fail_count);
      if (fail_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/pcc_pkg.sv
rtl/pcc_store.sv
rtl/psi_cycle_cutter_unit.sv
rtl/pcc_checker.sv
sim/tb.sv
